/* rtl/bale_pkg.sv */
package bale_pkg;

	localparam int Depth = 64;
	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	localparam logic [3:0] OP_PUSH    = 4'd0;
	localparam logic [3:0] OP_POP     = 4'd1;
	localparam logic [3:0] OP_INSERT  = 4'd2;
	localparam logic [3:0] OP_READ    = 4'd3;
	localparam logic [3:0] OP_FIND    = 4'd4;
	localparam logic [3:0] OP_SORT    = 4'd5;
	localparam logic [3:0] OP_REVERSE = 4'd6;
	localparam logic [3:0] OP_UNIQUE  = 4'd7;
	localparam logic [3:0] OP_CLEAR   = 4'd8;
	localparam logic [3:0] OP_FRONT   = 4'd9;
	localparam logic [3:0] OP_BACK    = 4'd10;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPOS   = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// memory access commands from the controller
	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic          wr_sel_in;   // write item value instead of read data
	} bale_cmd_t;

	typedef struct packed {
		logic [31:0] rd_data;
	} bale_sts_t;

endpackage

/* rtl/bale_datapath.sv */
module bale_datapath
	import bale_pkg::*;
(
	input  logic        clk,
	input  bale_cmd_t   cmd,
	input  logic [31:0] wr_item,
	input  logic [31:0] wr_data,
	output bale_sts_t   sts
);

	logic [31:0] mem [Depth];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_sel_in ? wr_item : wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
	end

	assign sts.rd_data = rd_q;

endmodule

/* rtl/bale_ctrl.sv */
module bale_ctrl
	import bale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [6:0]  position,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  found_position,
	output logic [6:0]  element_count,
	output logic        is_empty,
	output bale_cmd_t   cmd,
	output logic [31:0] wr_item,
	output logic [31:0] wr_data,
	input  bale_sts_t   sts
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD   = 11'b00000000010, // single read: issue, then capture
		S_INS  = 11'b00000000100, // insert shift: read i-1, write i
		S_FND  = 11'b00000001000,
		S_SRA  = 11'b00000010000, // sort: read j
		S_SRB  = 11'b00000100000, // sort: read j+1
		S_SRC  = 11'b00001000000, // compare, write lower on swap
		S_SWP  = 11'b00010000000, // write upper on swap
		S_REV  = 11'b00100000000,
		S_UNQ  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t        state_q, state_d;
	logic [3:0]    op_q, op_d;
	logic [CW-1:0] pos_q, pos_d, cnt_q, cnt_d, i_q, i_d, j_q, j_d;
	logic [CW-1:0] lim_q, lim_d, w_q, w_d;
	logic [31:0]   val_q, val_d, a_q, a_d;
	logic [1:0]    ph_q, ph_d;   // sub-phase within a state
	logic [2:0]    st_q, st_d;
	logic [31:0]   rv_q, rv_d;
	logic [6:0]    fp_q, fp_d;
	logic          swap_need, pass_end, last_pass, keep;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign read_value = rv_q;
	assign found_position = fp_q;
	assign element_count = 7'(cnt_q);
	assign is_empty = (cnt_q == '0);
	assign wr_item = val_q;

	assign swap_need = ($signed(sts.rd_data) < $signed(a_q));
	assign pass_end  = (j_q + 1'b1 >= lim_q);
	assign last_pass = (lim_q <= CW'(1));
	assign keep      = (i_q != '0) && (sts.rd_data != a_q);

	function automatic logic [AW-1:0] ad(input logic [CW-1:0] x);
		return x[AW-1:0];
	endfunction

	always_comb begin
		cmd = '0;
		wr_data = sts.rd_data;
		unique case (state_q)
			S_RD: begin
				cmd.rd_en = !ph_q[0];
				cmd.rd_addr = ad(pos_q);
			end
			S_INS: begin
				if (!ph_q[0]) begin
					cmd.rd_en = (i_q > pos_q);
					cmd.rd_addr = ad(i_q - 1'b1);
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_addr = ad(i_q);
					cmd.wr_sel_in = (i_q == pos_q);
				end
			end
			S_FND: begin
				cmd.rd_en = !ph_q[0];
				cmd.rd_addr = ad(i_q);
			end
			S_SRA: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = ad(j_q);
			end
			S_SRB: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = ad(j_q + 1'b1);
			end
			S_SRC: begin
				cmd.wr_en = swap_need;
				cmd.wr_addr = ad(j_q);
			end
			S_SWP: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = ad(j_q + 1'b1);
				wr_data = a_q;
			end
			S_REV: begin
				// phases: 0 read lo, 1 read hi, 2 write lo, 3 write hi
				unique case (ph_q)
					2'd0: begin
						cmd.rd_en = 1'b1;
						cmd.rd_addr = ad(i_q);
					end
					2'd1: begin
						cmd.rd_en = 1'b1;
						cmd.rd_addr = ad(j_q);
					end
					2'd2: begin
						cmd.wr_en = 1'b1;
						cmd.wr_addr = ad(i_q);
					end
					default: begin
						cmd.wr_en = 1'b1;
						cmd.wr_addr = ad(j_q);
						wr_data = a_q;
					end
				endcase
			end
			S_UNQ: begin
				if (!ph_q[0]) begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = ad(i_q);
				end else begin
					cmd.wr_en = keep;
					cmd.wr_addr = ad(w_q);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		pos_d = pos_q;
		cnt_d = cnt_q;
		i_d = i_q;
		j_d = j_q;
		lim_d = lim_q;
		w_d = w_q;
		val_d = val_q;
		a_d = a_q;
		ph_d = ph_q;
		st_d = st_q;
		rv_d = rv_q;
		fp_d = fp_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = opcode;
					pos_d = CW'(position);
					val_d = item_value;
					st_d = ST_OK;
					rv_d = '0;
					fp_d = '1;
					ph_d = '0;
					state_d = S_OUT;
					unique case (opcode)
						OP_PUSH: begin
							if (cnt_q >= CW'(Depth)) st_d = ST_FULL;
							else begin
								// write phase straight away at the end
								pos_d = cnt_q;
								i_d = cnt_q;
								ph_d = 2'd1;
								state_d = S_INS;
							end
						end
						OP_POP: begin
							if (cnt_q == '0) st_d = ST_EMPTY;
							else cnt_d = cnt_q - 1'b1;
						end
						OP_INSERT: begin
							if (CW'(position) > cnt_q) st_d = ST_BADPOS;
							else if (cnt_q >= CW'(Depth)) st_d = ST_FULL;
							else begin
								i_d = cnt_q;
								state_d = S_INS;
							end
						end
						OP_READ: begin
							if (CW'(position) >= cnt_q) begin
								st_d = ST_BADPOS;
								rv_d = '1;
							end else state_d = S_RD;
						end
						OP_FRONT, OP_BACK: begin
							if (cnt_q == '0) begin
								st_d = ST_EMPTY;
								rv_d = '1;
							end else begin
								pos_d = (opcode == OP_FRONT) ? '0 : cnt_q - 1'b1;
								state_d = S_RD;
							end
						end
						OP_FIND: begin
							st_d = ST_NOTFOUND;
							i_d = '0;
							if (cnt_q != '0) state_d = S_FND;
						end
						OP_SORT, OP_UNIQUE: begin
							j_d = '0;
							lim_d = cnt_q - 1'b1;
							if (cnt_q >= CW'(2)) state_d = S_SRA;
						end
						OP_REVERSE: begin
							i_d = '0;
							j_d = cnt_q - 1'b1;
							if (cnt_q >= CW'(2)) state_d = S_REV;
						end
						OP_CLEAR: cnt_d = '0;
						default: ;
					endcase
				end
			end
			S_RD: begin
				if (!ph_q[0]) ph_d = 2'd1;
				else begin
					rv_d = sts.rd_data;
					state_d = S_OUT;
				end
			end
			S_INS: begin
				if (!ph_q[0]) ph_d = 2'd1;
				else begin
					ph_d = '0;
					if (i_q == pos_q) begin
						cnt_d = cnt_q + 1'b1;
						state_d = S_OUT;
					end else i_d = i_q - 1'b1;
				end
			end
			S_FND: begin
				if (!ph_q[0]) ph_d = 2'd1;
				else begin
					ph_d = '0;
					if (sts.rd_data == val_q) begin
						st_d = ST_OK;
						fp_d = 7'(i_q);
						state_d = S_OUT;
					end else if (i_q + 1'b1 >= cnt_q) state_d = S_OUT;
					else i_d = i_q + 1'b1;
				end
			end
			S_SRA: state_d = S_SRB;
			S_SRB: begin
				a_d = sts.rd_data;
				state_d = S_SRC;
			end
			S_SRC, S_SWP: begin
				if (state_q == S_SRC && swap_need) state_d = S_SWP;
				else if (!pass_end) begin
					j_d = j_q + 1'b1;
					state_d = S_SRA;
				end else if (!last_pass) begin
					lim_d = lim_q - 1'b1;
					j_d = '0;
					state_d = S_SRA;
				end else if (op_q == OP_UNIQUE) begin
					i_d = '0;
					w_d = CW'(1);
					ph_d = '0;
					state_d = S_UNQ;
				end else state_d = S_OUT;
			end
			S_REV: begin
				unique case (ph_q)
					2'd0: ph_d = 2'd1;
					2'd1: begin
						a_d = sts.rd_data;
						ph_d = 2'd2;
					end
					2'd2: ph_d = 2'd3;
					default: begin
						ph_d = '0;
						i_d = i_q + 1'b1;
						j_d = j_q - 1'b1;
						if (i_q + 1'b1 >= j_q - 1'b1) state_d = S_OUT;
					end
				endcase
			end
			S_UNQ: begin
				// a_q holds the previous element of the sorted list
				if (!ph_q[0]) ph_d = 2'd1;
				else begin
					ph_d = '0;
					if (i_q == '0 || keep) a_d = sts.rd_data;
					if (keep) w_d = w_q + 1'b1;
					if (i_q + 1'b1 >= cnt_q) begin
						cnt_d = keep ? w_q + 1'b1 : w_q;
						state_d = S_OUT;
					end else i_d = i_q + 1'b1;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			lim_q <= '0;
			w_q <= '0;
			val_q <= '0;
			a_q <= '0;
			ph_q <= '0;
			st_q <= '0;
			rv_q <= '0;
			fp_q <= '0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			pos_q <= pos_d;
			cnt_q <= cnt_d;
			i_q <= i_d;
			j_q <= j_d;
			lim_q <= lim_d;
			w_q <= w_d;
			val_q <= val_d;
			a_q <= a_d;
			ph_q <= ph_d;
			st_q <= st_d;
			rv_q <= rv_d;
			fp_q <= fp_d;
		end
	end

endmodule

/* rtl/bounded_array_list_engine.sv */
// channel | signals                                   | role
// in      | in_valid, in_ready, opcode, position,     | one operation word
//         | item_value                                |
// out     | out_valid, out_ready, status, read_value, | one result word per operation
//         | found_position, element_count, is_empty   |
// pop, clear, errors and unused codes skip the memory; push writes one entry;
// read/front/back read one; insert shifts entries up one by one, find walks from the front,
// reverse swaps pairs from both ends, sort is a signed ascending bubble sort;
// unique sorts, then keeps each element that differs from the one before
// arst_n clears count and controller; memory holds no reset
// one operation at a time: in_ready is low until the result word is taken
module bounded_array_list_engine
	import bale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [6:0]  position,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  found_position,
	output logic [6:0]  element_count,
	output logic        is_empty
);

	bale_cmd_t   cmd;
	bale_sts_t   sts;
	logic [31:0] wr_item, wr_data;

	// controller: sequencing and result word
	bale_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .position, .item_value,
		.out_valid, .out_ready, .status, .read_value, .found_position,
		.element_count, .is_empty, .cmd, .wr_item, .wr_data, .sts
	);

	// datapath: element memory
	bale_datapath u_dp (
		.clk, .cmd, .wr_item, .wr_data, .sts
	);

	// never ready and valid at once
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready while result pending");

	// count stays within capacity
	assert property (@(posedge clk) disable iff (!arst_n) element_count <= 7'(Depth))
		else $error("count above capacity");

	// empty flag tracks count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (element_count == 7'd0)))
		else $error("empty flag mismatch");

endmodule

/* bench/bounded_array_list_engine_test.sv */
`timescale 1ns / 1ps

module bounded_array_list_engine_test;
	import bale_pkg::*;

	localparam int ListCap = Depth;
	localparam int RandomWords = 600;

	typedef struct packed {
		logic [3:0]  op;
		logic [6:0]  pos;
		logic [31:0] val;
	} op_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] rd_value;
		logic [6:0]  fpos;
		logic [6:0]  count;
		logic        empty;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  opcode = '0;
	logic [6:0]  position = '0;
	logic [31:0] item_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] read_value;
	logic [6:0]  found_position;
	logic [6:0]  element_count;
	logic        is_empty;

	op_word_t     pending_ops[$];
	list_result_t expected_results[$];

	// shadow of the list contents, updated as words are queued
	logic [31:0] shadow_list[ListCap];
	int          shadow_len = 0;

	int  fail_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  results_seen = 0;
	bit  burst_mode = 1'b0;
	bit  long_hold_done = 1'b0;

	bounded_array_list_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.read_value(read_value),
		.found_position(found_position),
		.element_count(element_count),
		.is_empty(is_empty)
	);

	always #6 clk = ~clk;

	// ascending bubble sort of the shadow list, signed compare
	function automatic void sort_shadow();
		logic [31:0] t;
		for (int p = 0; p + 1 < shadow_len; p++) begin
			for (int j = 0; j + 1 < shadow_len - p; j++) begin
				if ($signed(shadow_list[j + 1]) < $signed(shadow_list[j])) begin
					t = shadow_list[j];
					shadow_list[j] = shadow_list[j + 1];
					shadow_list[j + 1] = t;
				end
			end
		end
	endfunction

	// applies one operation word to the shadow list and returns the result word
	function automatic list_result_t apply_list_op(op_word_t w);
		list_result_t r;
		logic [31:0] t;
		int lo;
		int hi;
		int wr;
		r.status = ST_OK;
		r.rd_value = '0;
		r.fpos = 7'h7f;
		case (w.op)
			OP_PUSH: begin
				if (shadow_len >= ListCap) r.status = ST_FULL;
				else begin
					shadow_list[shadow_len] = w.val;
					shadow_len++;
				end
			end
			OP_POP: begin
				if (shadow_len == 0) r.status = ST_EMPTY;
				else shadow_len--;
			end
			OP_INSERT: begin
				if (w.pos > shadow_len) r.status = ST_BADPOS;
				else if (shadow_len >= ListCap) r.status = ST_FULL;
				else begin
					for (int i = shadow_len; i > w.pos; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[w.pos] = w.val;
					shadow_len++;
				end
			end
			OP_READ: begin
				if (w.pos >= shadow_len) begin
					r.status = ST_BADPOS;
					r.rd_value = '1;
				end else r.rd_value = shadow_list[w.pos];
			end
			OP_FIND: begin
				r.status = ST_NOTFOUND;
				for (int i = 0; i < shadow_len; i++) begin
					if (r.status == ST_NOTFOUND && shadow_list[i] == w.val) begin
						r.status = ST_OK;
						r.fpos = 7'(i);
					end
				end
			end
			OP_SORT: sort_shadow();
			OP_REVERSE: begin
				lo = 0;
				hi = shadow_len - 1;
				while (lo < hi) begin
					t = shadow_list[lo];
					shadow_list[lo] = shadow_list[hi];
					shadow_list[hi] = t;
					lo++;
					hi--;
				end
			end
			OP_UNIQUE: begin
				if (shadow_len > 1) begin
					sort_shadow();
					wr = 1;
					for (int i = 1; i < shadow_len; i++) begin
						if (shadow_list[i] != shadow_list[i - 1]) begin
							shadow_list[wr] = shadow_list[i];
							wr++;
						end
					end
					shadow_len = wr;
				end
			end
			OP_CLEAR: shadow_len = 0;
			OP_FRONT, OP_BACK: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
					r.rd_value = '1;
				end else if (w.op == OP_FRONT) r.rd_value = shadow_list[0];
				else r.rd_value = shadow_list[shadow_len - 1];
			end
			default: ;
		endcase
		r.count = 7'(shadow_len);
		r.empty = (shadow_len == 0);
		return r;
	endfunction

	function automatic void queue_op(logic [3:0] op, logic [6:0] pos, logic [31:0] val);
		op_word_t w;
		w.op = op;
		w.pos = pos;
		w.val = val;
		pending_ops = {pending_ops, w};
		expected_results = {expected_results, apply_list_op(w)};
	endfunction

	// small pool for duplicates and find hits, plus extremes and full-range values
	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return 32'($signed($urandom_range(0, 6)) - 3);
		if (sel == 5) return 32'h8000_0000;
		if (sel == 6) return 32'h7fff_ffff;
		return $urandom;
	endfunction

	function automatic logic [6:0] pick_position();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return 7'($urandom_range(0, shadow_len));
		if (sel < 8) return 7'(shadow_len);
		return 7'($urandom_range(0, 127));
	endfunction

	// stimulus
	initial begin
		int mode;
		int roll;
		logic [3:0] op;
		// empty-list corner cases, then directed cases on a short list
		queue_op(OP_POP, 7'd0, 32'd0);
		queue_op(OP_FRONT, 7'd0, 32'd0);
		queue_op(OP_BACK, 7'd0, 32'd0);
		queue_op(OP_READ, 7'd0, 32'd0);
		queue_op(OP_UNIQUE, 7'd0, 32'd0);
		queue_op(OP_FIND, 7'd0, 32'd5);
		queue_op(OP_INSERT, 7'd1, 32'd9);
		queue_op(4'd15, 7'd127, 32'hffff_ffff);
		queue_op(OP_PUSH, 7'd0, 32'h8000_0000);
		queue_op(OP_UNIQUE, 7'd0, 32'd0);
		queue_op(OP_PUSH, 7'd0, 32'h7fff_ffff);
		queue_op(OP_INSERT, 7'd0, 32'd3);
		queue_op(OP_INSERT, 7'd3, 32'd3);
		queue_op(OP_INSERT, 7'd64, 32'd1);
		queue_op(OP_READ, 7'd64, 32'd0);
		queue_op(OP_READ, 7'd1, 32'd0);
		queue_op(OP_FIND, 7'd0, 32'd3);
		queue_op(OP_FIND, 7'd0, 32'd4);
		queue_op(OP_SORT, 7'd0, 32'd0);
		queue_op(OP_FRONT, 7'd0, 32'd0);
		queue_op(OP_REVERSE, 7'd0, 32'd0);
		queue_op(OP_BACK, 7'd0, 32'd0);
		queue_op(OP_UNIQUE, 7'd0, 32'd0);
		queue_op(OP_CLEAR, 7'd0, 32'd0);
		queue_op(4'd11, 7'd5, 32'd0);

		// phases: grow towards full, mixed, mixed, shrink
		for (int i = 0; i < RandomWords; i++) begin
			mode = (i / 60) % 4;
			roll = $urandom_range(0, 99);
			if (mode == 0 && roll < 75) op = (roll < 60) ? OP_PUSH : OP_INSERT;
			else if (mode == 3 && roll < 40) op = (roll < 3) ? OP_CLEAR : OP_POP;
			else begin
				roll = $urandom_range(0, 99);
				if (roll < 18) op = OP_PUSH;
				else if (roll < 28) op = OP_POP;
				else if (roll < 40) op = OP_INSERT;
				else if (roll < 54) op = OP_READ;
				else if (roll < 66) op = OP_FIND;
				else if (roll < 69) op = OP_SORT;
				else if (roll < 74) op = OP_REVERSE;
				else if (roll < 77) op = OP_UNIQUE;
				else if (roll < 79) op = OP_CLEAR;
				else if (roll < 86) op = OP_FRONT;
				else if (roll < 93) op = OP_BACK;
				else if (roll < 96) op = 4'($urandom_range(11, 15));
				else op = 4'($urandom);
			end
			// find hits need values that are really stored
			if (op == OP_FIND && shadow_len > 0 && $urandom_range(0, 1))
				queue_op(op, 7'($urandom), shadow_list[$urandom_range(0, shadow_len - 1)]);
			else
				queue_op(op, pick_position(), pick_value());
		end
	end

	// reset and end of run
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, several times a run made only of full-list sorts with the longest stalls
	initial begin
		#300ms;
		$display("Simulation FAILED");
		$finish;
	end

	// driver: a word stays on the port until taken, then a random gap
	always @(posedge clk or negedge arst_n) begin
		op_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ops.size() > 0) begin
				w = pending_ops.pop_front();
				opcode <= w.op;
				position <= w.pos;
				item_value <= w.val;
				in_valid <= 1'b1;
				// runs of back-to-back words now and then
				if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
				gap_left <= burst_mode ? 0 : $urandom_range(0, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compares each result word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		list_result_t e;
		int next_stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			next_stall = stall_left;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word status %0d count %0d",
						$time, status, element_count);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status, status);
						fail_count++;
					end
					if (read_value !== e.rd_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, e.rd_value, read_value);
						fail_count++;
					end
					if (found_position !== e.fpos) begin
						$display("%0t: found_position expected %h actual %h",
							$time, e.fpos, found_position);
						fail_count++;
					end
					if (element_count !== e.count) begin
						$display("%0t: element_count expected %0d actual %0d",
							$time, e.count, element_count);
						fail_count++;
					end
					if (is_empty !== e.empty) begin
						$display("%0t: is_empty expected %b actual %b", $time, e.empty, is_empty);
						fail_count++;
					end
				end
				// one long hold-off so the sender sits against a busy block
				if (!long_hold_done && results_seen == 200) begin
					next_stall = 400;
					long_hold_done = 1'b1;
				end else begin
					next_stall = burst_mode ? 0 : $urandom_range(0, 11);
				end
			end else if (next_stall > 0) begin
				next_stall--;
			end
			stall_left <= next_stall;
			out_ready <= (next_stall == 0);
		end
	end

endmodule
